// ===== hdl/swfr_pkg.sv =====
`default_nettype none

package swfr_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned KIND_W = 3;
    localparam int unsigned CFG_INDEX_W = 3;

    localparam logic [KIND_W-1:0] KIND_DATA   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ACCEPT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FAIL   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DUP    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ABORT  = 3'd4;

    localparam logic [CFG_INDEX_W-1:0] REG_FLAG        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ESCAPE      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ESC_FLAG    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ESC_ESCAPE  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ADDRESS     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_CTRL_SEQ0   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_CTRL_SEQ1   = 3'd6;

    typedef struct packed {
        logic [BYTE_W-1:0] flag_value;
        logic [BYTE_W-1:0] escape_value;
        logic [BYTE_W-1:0] escaped_flag_value;
        logic [BYTE_W-1:0] escaped_escape_value;
        logic [BYTE_W-1:0] sender_address;
        logic [BYTE_W-1:0] info_control_seq0;
        logic [BYTE_W-1:0] info_control_seq1;
    } cfg_t;

    // A received byte together with its comparisons against the configuration.
    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              is_flag;
        logic              is_escape;
        logic              is_esc_flag;
        logic              is_esc_escape;
        logic              is_address;
        logic              is_seq0;
        logic              is_seq1;
    } class_t;

    typedef struct packed {
        logic [KIND_W-1:0] result_kind;
        logic [BYTE_W-1:0] data_byte;
        logic              reply_needed;
        logic              reply_reject;
        logic              reply_seq;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/swfr_front.sv =====
`default_nettype none

module swfr_front
(
    input  wire logic [swfr_pkg::BYTE_W-1:0] rx_byte,
    input  wire swfr_pkg::cfg_t               cfg,
    output swfr_pkg::class_t                  cls
);
    import swfr_pkg::*;

    always_comb
    begin
        cls.rx_byte       = rx_byte;
        cls.is_flag       = (rx_byte == cfg.flag_value);
        cls.is_escape     = (rx_byte == cfg.escape_value);
        cls.is_esc_flag   = (rx_byte == cfg.escaped_flag_value);
        cls.is_esc_escape = (rx_byte == cfg.escaped_escape_value);
        cls.is_address    = (rx_byte == cfg.sender_address);
        cls.is_seq0       = (rx_byte == cfg.info_control_seq0);
        cls.is_seq1       = (rx_byte == cfg.info_control_seq1);
    end

endmodule

`default_nettype wire

// ===== hdl/swfr_queue.sv =====
`default_nettype none

module swfr_queue
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire swfr_pkg::class_t push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  head_valid,
    output swfr_pkg::class_t      head_data
);
    import swfr_pkg::*;

    class_t     entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_data  = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/swfr_back.sv =====
`default_nettype none

module swfr_back
#(
    parameter int unsigned MAX_STUFFED_BYTES = 2048
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire swfr_pkg::cfg_t   cfg,
    input  wire logic             in_valid,
    input  wire swfr_pkg::class_t in_cls,
    output logic                  in_take,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output swfr_pkg::result_t     out_res
);
    import swfr_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_STUFFED_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_STUFFED_BYTES);

    typedef enum logic [2:0]
    {
        PH_HUNT = 3'd0,
        PH_FLAG = 3'd1,
        PH_ADDR = 3'd2,
        PH_CTRL = 3'd3,
        PH_DATA = 3'd4
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic              exp_seq_reg, exp_seq_next;
    logic              dup_reg, dup_next;
    logic [BYTE_W-1:0] hdr_reg, hdr_next;
    logic              esc_pend_reg, esc_pend_next;
    logic [BYTE_W-1:0] held_reg, held_next;
    logic              held_valid_reg, held_valid_next;
    logic [BYTE_W-1:0] check_reg, check_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_res_reg, out_res_next;

    logic              produce;
    result_t           res;
    logic              have;
    logic [BYTE_W-1:0] dest;
    logic              want;
    logic              again;

    assign in_take   = in_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    always_comb
    begin
        phase_next      = phase_reg;
        exp_seq_next    = exp_seq_reg;
        dup_next        = dup_reg;
        hdr_next        = hdr_reg;
        esc_pend_next   = esc_pend_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        check_next      = check_reg;
        cnt_next        = cnt_reg;
        produce         = 1'b0;
        res             = '0;
        have            = 1'b0;
        dest            = '0;
        want            = exp_seq_reg ? in_cls.is_seq1 : in_cls.is_seq0;
        again           = exp_seq_reg ? in_cls.is_seq0 : in_cls.is_seq1;

        if (in_take)
        begin
            case (phase_reg)
                PH_FLAG:
                begin
                    if (in_cls.is_flag)
                    begin
                        phase_next = PH_FLAG;
                    end
                    else if (in_cls.is_address)
                    begin
                        dup_next   = 1'b0;
                        hdr_next   = in_cls.rx_byte;
                        phase_next = PH_ADDR;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_ADDR:
                begin
                    dup_next = again;
                    if (in_cls.is_flag)
                    begin
                        phase_next = PH_FLAG;
                    end
                    else if (want || again)
                    begin
                        hdr_next   = hdr_reg ^ in_cls.rx_byte;
                        phase_next = PH_CTRL;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_CTRL:
                begin
                    if (in_cls.is_flag)
                    begin
                        phase_next = PH_FLAG;
                    end
                    else if (in_cls.rx_byte == hdr_reg)
                    begin
                        phase_next      = PH_DATA;
                        esc_pend_next   = 1'b0;
                        held_valid_next = 1'b0;
                        held_next       = '0;
                        check_next      = '0;
                        cnt_next        = '0;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_DATA:
                begin
                    if (cnt_reg >= CNT_MAX)
                    begin
                        phase_next      = PH_HUNT;
                        produce         = 1'b1;
                        res.result_kind = KIND_ABORT;
                    end
                    else if (in_cls.is_flag)
                    begin
                        phase_next    = PH_HUNT;
                        esc_pend_next = 1'b0;
                        produce       = 1'b1;
                        if (!held_valid_reg)
                        begin
                            res.result_kind = KIND_ABORT;
                        end
                        else if (dup_reg)
                        begin
                            res.result_kind  = KIND_DUP;
                            res.reply_needed = 1'b1;
                            res.reply_seq    = exp_seq_reg;
                        end
                        else if (check_reg != held_reg)
                        begin
                            res.result_kind  = KIND_FAIL;
                            res.reply_needed = 1'b1;
                            res.reply_reject = 1'b1;
                            res.reply_seq    = exp_seq_reg;
                        end
                        else
                        begin
                            res.result_kind  = KIND_ACCEPT;
                            res.reply_needed = 1'b1;
                            res.reply_seq    = !exp_seq_reg;
                            exp_seq_next     = !exp_seq_reg;
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                        if (esc_pend_reg)
                        begin
                            esc_pend_next = 1'b0;
                            if (in_cls.is_esc_flag)
                            begin
                                dest = cfg.flag_value;
                                have = 1'b1;
                            end
                            else if (in_cls.is_esc_escape)
                            begin
                                dest = cfg.escape_value;
                                have = 1'b1;
                            end
                        end
                        else if (in_cls.is_escape)
                        begin
                            esc_pend_next = 1'b1;
                        end
                        else
                        begin
                            dest = in_cls.rx_byte;
                            have = 1'b1;
                        end
                        if (have)
                        begin
                            if (held_valid_reg)
                            begin
                                check_next = check_reg ^ held_reg;
                                if (!dup_reg)
                                begin
                                    produce         = 1'b1;
                                    res.result_kind = KIND_DATA;
                                    res.data_byte   = held_reg;
                                end
                            end
                            held_next       = dest;
                            held_valid_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                    phase_next = in_cls.is_flag ? PH_FLAG : PH_HUNT;
                end
            endcase
        end

        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (in_take && produce)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            exp_seq_reg    <= 1'b0;
            dup_reg        <= 1'b0;
            hdr_reg        <= '0;
            esc_pend_reg   <= 1'b0;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            check_reg      <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_res_reg    <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            exp_seq_reg    <= exp_seq_next;
            dup_reg        <= dup_next;
            hdr_reg        <= hdr_next;
            esc_pend_reg   <= esc_pend_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            check_reg      <= check_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
            out_res_reg    <= out_res_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/stop_and_wait_frame_receiver.sv =====
// Path: a taken byte is written into the queue, the frame state machine takes it from there,
// and any result it yields is held in the output register until the output handshake.
// Throughput: one received byte per cycle; a stalled output fills the two-entry queue
// between the byte classifier and the frame state machine before the input stalls.
// Reset: rst_n clears the frame state, the expected sequence bit, the queue and the
// output register at once, and restores the configuration registers to their defaults.
`default_nettype none

module stop_and_wait_frame_receiver
#(
    parameter int unsigned MAX_STUFFED_BYTES = 2048
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [7:0]                       s_tdata,   // rx_byte[7:0]
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // data_byte[7:0], reply_needed[8], reply_reject[9], reply_seq[10], zeros above
    output logic [15:0]                           m_tdata,
    output logic [2:0]                            m_tuser,   // result_kind[2:0]
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [swfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]                       cfg_data
);
    import swfr_pkg::*;

    cfg_t    cfg_reg;
    class_t  front_cls;
    class_t  head_cls;
    logic    q_full;
    logic    head_valid;
    logic    take;
    result_t res;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flag_value          <= 8'd126;
            cfg_reg.escape_value        <= 8'd125;
            cfg_reg.escaped_flag_value  <= 8'd94;
            cfg_reg.escaped_escape_value <= 8'd93;
            cfg_reg.sender_address      <= 8'd3;
            cfg_reg.info_control_seq0   <= 8'd0;
            cfg_reg.info_control_seq1   <= 8'd64;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_FLAG:       cfg_reg.flag_value           <= cfg_data;
                REG_ESCAPE:     cfg_reg.escape_value         <= cfg_data;
                REG_ESC_FLAG:   cfg_reg.escaped_flag_value   <= cfg_data;
                REG_ESC_ESCAPE: cfg_reg.escaped_escape_value <= cfg_data;
                REG_ADDRESS:    cfg_reg.sender_address       <= cfg_data;
                REG_CTRL_SEQ0:  cfg_reg.info_control_seq0    <= cfg_data;
                REG_CTRL_SEQ1:  cfg_reg.info_control_seq1    <= cfg_data;
                default:        cfg_reg                      <= cfg_reg;
            endcase
        end
    end

    swfr_front u_front
    (
        .rx_byte (s_tdata),
        .cfg     (cfg_reg),
        .cls     (front_cls)
    );

    swfr_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (s_tvalid),
        .push_data  (front_cls),
        .full       (q_full),
        .pop        (take),
        .head_valid (head_valid),
        .head_data  (head_cls)
    );

    swfr_back
    #(
        .MAX_STUFFED_BYTES (MAX_STUFFED_BYTES)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (head_valid),
        .in_cls    (head_cls),
        .in_take   (take),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tuser = res.result_kind;
    assign m_tdata = {5'd0, res.reply_seq, res.reply_reject, res.reply_needed, res.data_byte};

endmodule

`default_nettype wire

// ===== hdl/swfr_checker.sv =====
`default_nettype none

module swfr_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [2:0]  m_tuser
);
    import swfr_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Result word changed while stalled.");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser <= KIND_ABORT))
        else $error("Result kind out of range.");

    a_data_no_reply: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_DATA || m_tuser == KIND_ABORT) |-> (m_tdata[15:8] == 8'd0))
        else $error("Data or abort word carries reply bits.");

    a_reply_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_ACCEPT || m_tuser == KIND_FAIL || m_tuser == KIND_DUP)
        |-> (m_tdata[7:0] == 8'd0) && m_tdata[8] && (m_tdata[9] == (m_tuser == KIND_FAIL)))
        else $error("Frame end word has wrong reply fields.");

endmodule

bind stop_and_wait_frame_receiver swfr_checker u_swfr_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== tb/stop_and_wait_frame_receiver_tb.sv =====
`default_nettype none

module stop_and_wait_frame_receiver_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import swfr_pkg::*;

    localparam int unsigned MAX_FRAME_BYTES = 2048;
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned LONG_HOLD = 300;
    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef enum logic [2:0] {
        RX_HUNT,
        RX_FLAG,
        RX_ADDR,
        RX_CTRL,
        RX_DATA
    } rx_phase_t;

    typedef enum int {
        FR_GOOD,
        FR_BAD_CHECK,
        FR_BAD_ADDR,
        FR_BAD_CTRL,
        FR_BAD_HEADER,
        FR_TRUNCATED,
        FR_LONE_ESCAPE,
        FR_EMPTY,
        FR_RESTART,
        FR_NOISE
    } frame_flavor_t;

    // Default settings: two opening flags, payload 00 FF 7E 7D, a lone escape pair,
    // check byte, an escape right before the closing flag; then a header restart
    // followed by an empty frame.
    localparam logic [7:0] DIRECTED [23] = '{
        8'h7E, 8'h7E, 8'h03, 8'h00, 8'h03, 8'h00, 8'hFF, 8'h7D,
        8'h5E, 8'h7D, 8'h5D, 8'h7D, 8'h41, 8'hFC, 8'h7D, 8'h7E,
        8'h7E, 8'h03, 8'h7E, 8'h03, 8'h40, 8'h43, 8'h7E
    };

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [15:0]            m_tdata;
    logic [2:0]             m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [7:0]             cfg_data = '0;

    stop_and_wait_frame_receiver #(
        .MAX_STUFFED_BYTES(MAX_FRAME_BYTES)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    cfg_t       settings = '{8'd126, 8'd125, 8'd94, 8'd93, 8'd3, 8'd0, 8'd64};
    rx_phase_t  rx_phase = RX_HUNT;
    logic       seq_expected = 1'b0;
    logic       repeat_frame = 1'b0;
    logic [7:0] header_xor = '0;
    logic       escape_seen = 1'b0;
    logic [7:0] held_data = '0;
    logic       held_ok = 1'b0;
    logic [7:0] payload_xor = '0;
    int unsigned frame_bytes = 0;

    logic [7:0] line_bytes[$];
    logic [7:0] frame_buf[$];
    result_t    frame_reports[$];
    int unsigned queued_count = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    logic        hold_toggle = 1'b0;
    logic        hold_seen = 1'b0;
    int unsigned hold_left = 0;

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic void add_report(logic [2:0] kind, logic [7:0] data, logic need,
                                       logic rej, logic seq);
        result_t r;
        r.result_kind = kind;
        r.data_byte = data;
        r.reply_needed = need;
        r.reply_reject = rej;
        r.reply_seq = seq;
        frame_reports.push_back(r);
    endfunction

    task automatic decode_line_byte(input logic [7:0] b);
        logic [7:0] want;
        logic [7:0] again;
        logic [7:0] d;
        logic       have;
        want = seq_expected ? settings.info_control_seq1 : settings.info_control_seq0;
        again = seq_expected ? settings.info_control_seq0 : settings.info_control_seq1;
        d = '0;
        have = 1'b0;
        case (rx_phase)
            RX_FLAG:
            begin
                if (b == settings.flag_value)
                begin
                end
                else if (b == settings.sender_address)
                begin
                    repeat_frame = 1'b0;
                    header_xor = b;
                    rx_phase = RX_ADDR;
                end
                else
                begin
                    rx_phase = RX_HUNT;
                end
            end
            RX_ADDR:
            begin
                repeat_frame = (b == again);
                if (b == settings.flag_value)
                begin
                    rx_phase = RX_FLAG;
                end
                else if (b == want || repeat_frame)
                begin
                    header_xor = header_xor ^ b;
                    rx_phase = RX_CTRL;
                end
                else
                begin
                    rx_phase = RX_HUNT;
                end
            end
            RX_CTRL:
            begin
                if (b == settings.flag_value)
                begin
                    rx_phase = RX_FLAG;
                end
                else if (b == header_xor)
                begin
                    rx_phase = RX_DATA;
                    escape_seen = 1'b0;
                    held_ok = 1'b0;
                    held_data = '0;
                    payload_xor = '0;
                    frame_bytes = 0;
                end
                else
                begin
                    rx_phase = RX_HUNT;
                end
            end
            RX_DATA:
            begin
                if (frame_bytes >= MAX_FRAME_BYTES)
                begin
                    rx_phase = RX_HUNT;
                    add_report(KIND_ABORT, '0, 1'b0, 1'b0, 1'b0);
                end
                else if (b == settings.flag_value)
                begin
                    rx_phase = RX_HUNT;
                    escape_seen = 1'b0;
                    if (!held_ok)
                    begin
                        add_report(KIND_ABORT, '0, 1'b0, 1'b0, 1'b0);
                    end
                    else if (repeat_frame)
                    begin
                        add_report(KIND_DUP, '0, 1'b1, 1'b0, seq_expected);
                    end
                    else if (payload_xor != held_data)
                    begin
                        add_report(KIND_FAIL, '0, 1'b1, 1'b1, seq_expected);
                    end
                    else
                    begin
                        add_report(KIND_ACCEPT, '0, 1'b1, 1'b0, ~seq_expected);
                        seq_expected = ~seq_expected;
                    end
                end
                else
                begin
                    frame_bytes++;
                    if (escape_seen)
                    begin
                        escape_seen = 1'b0;
                        if (b == settings.escaped_flag_value)
                        begin
                            d = settings.flag_value;
                            have = 1'b1;
                        end
                        else if (b == settings.escaped_escape_value)
                        begin
                            d = settings.escape_value;
                            have = 1'b1;
                        end
                    end
                    else if (b == settings.escape_value)
                    begin
                        escape_seen = 1'b1;
                    end
                    else
                    begin
                        d = b;
                        have = 1'b1;
                    end
                    if (have)
                    begin
                        if (held_ok)
                        begin
                            payload_xor = payload_xor ^ held_data;
                            if (!repeat_frame)
                            begin
                                add_report(KIND_DATA, held_data, 1'b0, 1'b0, 1'b0);
                            end
                        end
                        held_data = d;
                        held_ok = 1'b1;
                    end
                end
            end
            default:
            begin
                rx_phase = (b == settings.flag_value) ? RX_FLAG : RX_HUNT;
            end
        endcase
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                decode_line_byte(s_tdata);
                void'(line_bytes.pop_front());
            end
            if (!s_tvalid || s_tready)
            begin
                if (line_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= line_bytes[0];
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_toggle != hold_seen)
        begin
            hold_seen <= hold_toggle;
            hold_left <= LONG_HOLD;
            m_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (frame_reports.size() == 0)
            begin
                $error("Output word with no result pending: kind %0d data %0d",
                       m_tuser, m_tdata[7:0]);
                error_count++;
            end
            else
            begin
                want = frame_reports.pop_front();
                check_field("result_kind", 8'(want.result_kind), 8'(m_tuser));
                check_field("data_byte", want.data_byte, m_tdata[7:0]);
                check_field("reply_needed", 8'(want.reply_needed), 8'(m_tdata[8]));
                check_field("reply_reject", 8'(want.reply_reject), 8'(m_tdata[9]));
                check_field("reply_seq", 8'(want.reply_seq), 8'(m_tdata[10]));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic queue_byte(input logic [7:0] b);
        line_bytes.push_back(b);
        queued_count++;
    endtask

    task automatic wait_until_idle();
        while (line_bytes.size() != 0 || frame_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        case (idx)
            REG_FLAG:       settings.flag_value = val;
            REG_ESCAPE:     settings.escape_value = val;
            REG_ESC_FLAG:   settings.escaped_flag_value = val;
            REG_ESC_ESCAPE: settings.escaped_escape_value = val;
            REG_ADDRESS:    settings.sender_address = val;
            REG_CTRL_SEQ0:  settings.info_control_seq0 = val;
            REG_CTRL_SEQ1:  settings.info_control_seq1 = val;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input cfg_t c);
        write_reg(REG_FLAG, c.flag_value);
        write_reg(REG_ESCAPE, c.escape_value);
        write_reg(REG_ESC_FLAG, c.escaped_flag_value);
        write_reg(REG_ESC_ESCAPE, c.escaped_escape_value);
        write_reg(REG_ADDRESS, c.sender_address);
        write_reg(REG_CTRL_SEQ0, c.info_control_seq0);
        write_reg(REG_CTRL_SEQ1, c.info_control_seq1);
        cfg_valid <= 1'b0;
    endtask

    function automatic cfg_t random_settings(logic equal_controls);
        cfg_t c;
        c.flag_value = 8'($urandom_range(255));
        c.escape_value = c.flag_value ^ 8'($urandom_range(1, 255));
        c.escaped_flag_value = 8'($urandom_range(255));
        c.escaped_escape_value = c.escaped_flag_value ^ 8'($urandom_range(1, 255));
        c.sender_address = c.flag_value ^ 8'($urandom_range(1, 255));
        c.info_control_seq0 = 8'($urandom_range(255));
        c.info_control_seq1 = equal_controls ? c.info_control_seq0
                                             : c.info_control_seq0 ^ 8'($urandom_range(1, 255));
        return c;
    endfunction

    // Payload bytes lean toward the delimiter values so that stuffing is exercised often.
    function automatic logic [7:0] pick_payload();
        case ($urandom_range(7))
            0: return settings.flag_value;
            1: return settings.escape_value;
            2: return settings.escaped_flag_value;
            3: return settings.escaped_escape_value;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic add_stuffed(input logic [7:0] b);
        if (b == settings.flag_value)
        begin
            frame_buf.push_back(settings.escape_value);
            frame_buf.push_back(settings.escaped_flag_value);
        end
        else if (b == settings.escape_value)
        begin
            frame_buf.push_back(settings.escape_value);
            frame_buf.push_back(settings.escaped_escape_value);
        end
        else
        begin
            frame_buf.push_back(b);
        end
    endtask

    task automatic queue_frame(input frame_flavor_t flavor);
        logic [7:0] ctrl;
        logic [7:0] hdr;
        logic [7:0] chk;
        logic [7:0] b;
        int         len;
        int         lone_at;
        int         keep;
        frame_buf.delete();
        if (flavor == FR_NOISE)
        begin
            repeat ($urandom_range(1, 8)) frame_buf.push_back(8'($urandom_range(255)));
        end
        else
        begin
            ctrl = $urandom_range(1) ? settings.info_control_seq1 : settings.info_control_seq0;
            hdr = settings.sender_address ^ ctrl;
            len = ($urandom_range(19) == 0) ? int'($urandom_range(60)) : int'($urandom_range(12));
            lone_at = (flavor == FR_LONE_ESCAPE) ? int'($urandom_range(len)) : -1;
            frame_buf.push_back(settings.flag_value);
            if ($urandom_range(9) == 0)
            begin
                frame_buf.push_back(settings.flag_value);
            end
            if (flavor == FR_RESTART)
            begin
                frame_buf.push_back(settings.sender_address);
                frame_buf.push_back(settings.flag_value);
            end
            frame_buf.push_back(flavor == FR_BAD_ADDR
                                ? settings.sender_address ^ 8'($urandom_range(1, 255))
                                : settings.sender_address);
            frame_buf.push_back(flavor == FR_BAD_CTRL ? ctrl ^ 8'($urandom_range(1, 255)) : ctrl);
            frame_buf.push_back(flavor == FR_BAD_HEADER ? hdr ^ 8'($urandom_range(1, 255)) : hdr);
            if (flavor != FR_EMPTY)
            begin
                chk = '0;
                for (int i = 0; i < len; i++)
                begin
                    if (i == lone_at)
                    begin
                        frame_buf.push_back(settings.escape_value);
                        frame_buf.push_back(8'($urandom_range(255)));
                    end
                    b = pick_payload();
                    chk = chk ^ b;
                    add_stuffed(b);
                end
                if (flavor == FR_BAD_CHECK)
                begin
                    chk = chk ^ 8'($urandom_range(1, 255));
                end
                add_stuffed(chk);
                if (lone_at == len)
                begin
                    frame_buf.push_back(settings.escape_value);
                end
            end
            frame_buf.push_back(settings.flag_value);
            if (flavor == FR_TRUNCATED)
            begin
                keep = $urandom_range(1, frame_buf.size() - 1);
                while (frame_buf.size() > keep)
                begin
                    void'(frame_buf.pop_back());
                end
            end
        end
        foreach (frame_buf[i])
        begin
            queue_byte(frame_buf[i]);
        end
    endtask

    task automatic queue_traffic(input int unsigned count);
        int unsigned start;
        int unsigned r;
        frame_flavor_t flavor;
        start = queued_count;
        while (queued_count - start < count)
        begin
            r = $urandom_range(99);
            if (r < 62)      flavor = FR_GOOD;
            else if (r < 70) flavor = FR_BAD_CHECK;
            else if (r < 74) flavor = FR_BAD_ADDR;
            else if (r < 78) flavor = FR_BAD_CTRL;
            else if (r < 82) flavor = FR_BAD_HEADER;
            else if (r < 86) flavor = FR_TRUNCATED;
            else if (r < 90) flavor = FR_LONE_ESCAPE;
            else if (r < 93) flavor = FR_EMPTY;
            else if (r < 96) flavor = FR_RESTART;
            else             flavor = FR_NOISE;
            queue_frame(flavor);
        end
    endtask

    function automatic cfg_t make_cfg(logic [7:0] flag, logic [7:0] esc, logic [7:0] esc_flag,
                                      logic [7:0] esc_esc, logic [7:0] addr,
                                      logic [7:0] seq0, logic [7:0] seq1);
        cfg_t c;
        c.flag_value = flag;
        c.escape_value = esc;
        c.escaped_flag_value = esc_flag;
        c.escaped_escape_value = esc_esc;
        c.sender_address = addr;
        c.info_control_seq0 = seq0;
        c.info_control_seq1 = seq1;
        return c;
    endfunction

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The sender pauses mid-frame until the pipeline has drained.
        send_idle_pct <= 25;
        recv_stall_pct <= 25;
        for (int i = 0; i < 8; i++)
        begin
            queue_byte(DIRECTED[i]);
        end
        wait_until_idle();
        for (int i = 8; i < 23; i++)
        begin
            queue_byte(DIRECTED[i]);
        end
        wait_until_idle();

        send_idle_pct <= 0;
        recv_stall_pct <= 0;
        queue_traffic(100);
        wait_until_idle();

        apply_settings(make_cfg(8'hFF, 8'h00, 8'hFE, 8'h01, 8'h80, 8'h00, 8'hFE));
        queue_traffic(380);
        hold_toggle <= ~hold_toggle;
        wait_until_idle();

        apply_settings(make_cfg(8'h00, 8'hFF, 8'h01, 8'hFE, 8'hFF, 8'h7F, 8'h80));
        send_idle_pct <= 64;
        queue_traffic(380);
        wait_until_idle();

        apply_settings(random_settings(1'b0));
        send_idle_pct <= 0;
        recv_stall_pct <= 64;
        queue_traffic(380);
        wait_until_idle();

        apply_settings(random_settings(1'b1));
        send_idle_pct <= 25;
        recv_stall_pct <= 25;
        queue_traffic(40);
        wait_until_idle();

        apply_settings(make_cfg(8'd126, 8'd125, 8'd94, 8'd93, 8'd3, 8'd0, 8'd64));
        queue_traffic(380);
        wait_until_idle();

        if (frame_reports.size() != 0)
        begin
            $error("%0d results never arrived", frame_reports.size());
            error_count++;
        end
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
